/* rtl/ldsbw_pkg.sv */
// ----------------------------------------------------------------------------
// ldsbw_pkg
// Shared types and constants of the multiplexed seven-segment scanner.
// ----------------------------------------------------------------------------
package ldsbw_pkg;

  localparam int OP_W     = 3;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 24;
  localparam int TIME_W   = 32;
  localparam int MS_W     = 16;
  localparam int SEG_W    = 8;
  localparam int ORDER_W  = 24;
  localparam int STEP_W   = 4;
  localparam int IN_DW    = 16;
  localparam int OUT_DW   = 24;

  // request opcodes
  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_SCAN      = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE     = 3'd2;
  localparam logic [OP_W-1:0] OP_BLINK_ON  = 3'd3;
  localparam logic [OP_W-1:0] OP_BLINK_OFF = 3'd4;
  localparam logic [OP_W-1:0] OP_WAIT_ON   = 3'd5;
  localparam logic [OP_W-1:0] OP_WAIT_OFF  = 3'd6;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_BLINK_ON   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_BLINK_OFF  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_WAIT_STEP  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_BLINK_MASK = 3'd3;
  localparam logic [CFG_IW-1:0] REG_ORDER      = 3'd4;
  localparam logic [CFG_IW-1:0] REG_WAIT_PAT   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_BLANK_PAT  = 3'd6;

  // register reset values
  localparam logic [MS_W-1:0]    BLINK_ON_RST   = 16'd500;
  localparam logic [MS_W-1:0]    BLINK_OFF_RST  = 16'd500;
  localparam logic [MS_W-1:0]    WAIT_STEP_RST  = 16'd250;
  localparam logic [SEG_W-1:0]   BLINK_MASK_RST = 8'hFF;
  localparam logic [ORDER_W-1:0] ORDER_RST      = 24'd16434824;
  localparam logic [SEG_W-1:0]   WAIT_PAT_RST   = 8'hBF;
  localparam logic [SEG_W-1:0]   BLANK_PAT_RST  = 8'hFF;

  // result kinds
  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  // operands of the shared elapsed-time comparator
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] start;
    logic [MS_W-1:0]   limit;
  } cmp_req_t;

endpackage

/* rtl/ldsbw_cmp.sv */
// ----------------------------------------------------------------------------
// ldsbw_cmp
// Shared timer unit: wrapping elapsed time compared against a limit.
// ----------------------------------------------------------------------------
module ldsbw_cmp (
  input  ldsbw_pkg::cmp_req_t req,
  output logic                gt
);
  import ldsbw_pkg::*;

  logic [TIME_W-1:0] elapsed;

  assign elapsed = req.now - req.start;
  assign gt      = elapsed > {{(TIME_W-MS_W){1'b0}}, req.limit};

endmodule

/* rtl/led_digit_scan_blink_wait.sv */
// ----------------------------------------------------------------------------
// led_digit_scan_blink_wait
// Multiplexed seven-segment scanner with blink phases and a wait animation.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  in_      | sink      | in_tvalid/in_tready   | tuser op, tdata segments, index
//  out_     | source    | out_tvalid/out_tready | tuser kind, tdata word/ok, tlast
//  cfg_     | sink      | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A scan steps through the blink, wait and scan states, plus a blank state for
// a dark-phase entry (one blank word a cycle while the result is not stalled)
// plus a fill state when the wait animation rewrites the buffer (one slot a
// cycle); both timer checks share one subtract/compare unit.
// Reset clears the control state and restores register defaults; cfg is always ready.
// A stalled result holds the sequencer; in_tready is high only when idle.
// ----------------------------------------------------------------------------
module led_digit_scan_blink_wait #(
  parameter int DIGITS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // tdata: [7:0] segments, [10:8] digit_index
  input  logic [ldsbw_pkg::IN_DW-1:0]  in_tdata,
  // tuser: [2:0] op
  input  logic [ldsbw_pkg::OP_W-1:0]   in_tuser,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // tdata: [7:0] segment_byte, [15:8] port_byte, [16] ok
  output logic [ldsbw_pkg::OUT_DW-1:0] out_tdata,
  // tuser: [0] kind
  output logic                         out_tuser,
  output logic                         out_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [ldsbw_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ldsbw_pkg::CFG_DW-1:0] cfg_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready
);
  import ldsbw_pkg::*;

  localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [IW-1:0]     LAST_SLOT = IW'(DIGITS - 1);
  localparam logic [STEP_W-1:0] DIGITS_W  = STEP_W'(DIGITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BLINK = 3'd1;
  localparam logic [2:0] S_BLANK = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_ACK   = 3'd6;

  localparam logic [1:0] FILL_BLANK = 2'd0;
  localparam logic [1:0] FILL_ANIM  = 2'd1;
  localparam logic [1:0] FILL_CLEAR = 2'd2;

  // configuration
  logic [MS_W-1:0]    blink_on_r, blink_off_r, wait_step_ms_r;
  logic [SEG_W-1:0]   blink_mask_r, wait_pat_r, blank_pat_r;
  logic [ORDER_W-1:0] order_r;

  // state
  logic [SEG_W-1:0]  buf_r [DIGITS];
  logic [2:0]        state_r, state_nxt;
  logic [IW-1:0]     scan_idx_r, scan_idx_nxt;
  logic [IW-1:0]     cnt_r, cnt_nxt;
  logic [1:0]        fill_mode_r, fill_mode_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              blink_active_r, blink_active_nxt;
  logic              blink_lit_r, blink_lit_nxt;
  logic              blink_timing_r, blink_timing_nxt;
  logic [TIME_W-1:0] blink_start_r, blink_start_nxt;
  logic              wait_active_r, wait_active_nxt;
  logic              wait_timing_r, wait_timing_nxt;
  logic [TIME_W-1:0] wait_start_r, wait_start_nxt;
  logic [STEP_W-1:0] wait_step_r, wait_step_nxt;
  logic              ok_r, ok_nxt;

  // result register
  logic              out_valid_r;
  logic              out_kind_r, out_ok_r, out_last_r;
  logic [SEG_W-1:0]  out_seg_r, out_port_r;

  logic              out_free;
  logic              emit, emit_kind, emit_ok, emit_last;
  logic [SEG_W-1:0]  emit_seg, emit_port;
  logic              buf_we;
  logic [IW-1:0]     buf_waddr;
  logic [SEG_W-1:0]  buf_wdata;
  cmp_req_t          cmp_req;
  logic              cmp_gt;
  logic [2:0]        slot3, pos;
  logic              slot_masked, fits;
  logic [STEP_W-1:0] fill_dist;
  logic [SEG_W-1:0]  in_seg;
  logic [2:0]        in_idx;

  assign in_seg      = in_tdata[7:0];
  assign in_idx      = in_tdata[10:8];
  assign fits        = {1'b0, in_idx} < DIGITS_W;
  assign slot3       = 3'(scan_idx_r);
  assign slot_masked = blink_mask_r[slot3];
  assign pos         = order_r[3*slot3 +: 3];
  assign fill_dist   = DIGITS_W - STEP_W'(cnt_r);
  assign out_free    = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DW-2*SEG_W-1){1'b0}}, out_ok_r, out_port_r, out_seg_r};

  // shared timer compare, operands picked by the sequencer
  always_comb begin
    cmp_req.now = now_r;
    if (state_r == S_WAIT) begin
      cmp_req.start = wait_start_r;
      cmp_req.limit = wait_step_ms_r;
    end else begin
      cmp_req.start = blink_start_r;
      cmp_req.limit = blink_lit_r ? blink_on_r : blink_off_r;
    end
  end

  ldsbw_cmp u_cmp (
    .req (cmp_req),
    .gt  (cmp_gt)
  );

  always_comb begin
    state_nxt        = state_r;
    scan_idx_nxt     = scan_idx_r;
    cnt_nxt          = cnt_r;
    fill_mode_nxt    = fill_mode_r;
    now_nxt          = now_r;
    blink_active_nxt = blink_active_r;
    blink_lit_nxt    = blink_lit_r;
    blink_timing_nxt = blink_timing_r;
    blink_start_nxt  = blink_start_r;
    wait_active_nxt  = wait_active_r;
    wait_timing_nxt  = wait_timing_r;
    wait_start_nxt   = wait_start_r;
    wait_step_nxt    = wait_step_r;
    ok_nxt           = ok_r;
    buf_we           = 1'b0;
    buf_waddr        = cnt_r;
    buf_wdata        = blank_pat_r;
    emit             = 1'b0;
    emit_kind        = KIND_WORD;
    emit_seg         = '0;
    emit_port        = '0;
    emit_ok          = 1'b0;
    emit_last        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            OP_TICK: now_nxt = now_r + 1'b1;
            OP_SCAN: state_nxt = S_BLINK;
            OP_WRITE: begin
              ok_nxt    = fits;
              buf_we    = fits;
              buf_waddr = in_idx[IW-1:0];
              buf_wdata = in_seg;
              state_nxt = S_ACK;
            end
            OP_BLINK_ON: begin
              ok_nxt = !blink_active_r;
              if (!blink_active_r) begin
                blink_timing_nxt = 1'b0;
                blink_lit_nxt    = 1'b0;
                blink_active_nxt = 1'b1;
              end
              state_nxt = S_ACK;
            end
            OP_BLINK_OFF: begin
              ok_nxt = blink_active_r;
              if (blink_active_r) begin
                blink_active_nxt = 1'b0;
                blink_timing_nxt = 1'b0;
                blink_lit_nxt    = 1'b1;
              end
              state_nxt = S_ACK;
            end
            OP_WAIT_ON: begin
              ok_nxt = !wait_active_r;
              if (!wait_active_r) begin
                wait_timing_nxt = 1'b0;
                wait_step_nxt   = '0;
                wait_active_nxt = 1'b1;
              end
              state_nxt = S_ACK;
            end
            OP_WAIT_OFF: begin
              ok_nxt = wait_active_r;
              if (wait_active_r) begin
                wait_active_nxt = 1'b0;
                wait_timing_nxt = 1'b0;
                cnt_nxt         = '0;
                fill_mode_nxt   = FILL_CLEAR;
                state_nxt       = S_FILL;
              end else begin
                state_nxt = S_ACK;
              end
            end
            default: ;
          endcase
        end
      end

      S_BLINK: begin
        state_nxt = S_WAIT;
        if (blink_active_r) begin
          if (!blink_timing_r) begin
            blink_start_nxt  = now_r;
            blink_timing_nxt = 1'b1;
            // entering the dark phase blanks every port first
            if (!blink_lit_r) begin
              cnt_nxt   = '0;
              state_nxt = S_BLANK;
            end
          end else if (cmp_gt) begin
            blink_timing_nxt = 1'b0;
            blink_lit_nxt    = !blink_lit_r;
          end
        end
      end

      S_BLANK: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_seg  = blank_pat_r;
          emit_port = SEG_W'(1) << cnt_r;
          // last only if the dark slot word will be suppressed
          emit_last = (cnt_r == LAST_SLOT) && slot_masked;
          if (cnt_r == LAST_SLOT) begin
            state_nxt = S_WAIT;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      S_WAIT: begin
        state_nxt = S_SCAN;
        if (wait_active_r) begin
          if (!wait_timing_r) begin
            wait_start_nxt  = now_r;
            wait_timing_nxt = 1'b1;
            cnt_nxt         = '0;
            fill_mode_nxt   = FILL_BLANK;
            state_nxt       = S_FILL;
          end else if (cmp_gt) begin
            wait_start_nxt = now_r;
            cnt_nxt        = '0;
            fill_mode_nxt  = FILL_ANIM;
            state_nxt      = S_FILL;
          end
        end
      end

      S_FILL: begin
        buf_we    = 1'b1;
        buf_waddr = cnt_r;
        buf_wdata = (fill_mode_r == FILL_ANIM && fill_dist <= wait_step_r) ? wait_pat_r
                                                                           : blank_pat_r;
        if (cnt_r == LAST_SLOT) begin
          cnt_nxt = '0;
          if (fill_mode_r == FILL_ANIM) begin
            wait_step_nxt = (wait_step_r >= DIGITS_W) ? '0 : wait_step_r + 1'b1;
          end
          state_nxt = (fill_mode_r == FILL_CLEAR) ? S_ACK : S_SCAN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_SCAN: begin
        if (blink_active_r && !blink_lit_r && slot_masked) begin
          scan_idx_nxt = (scan_idx_r == LAST_SLOT) ? '0 : scan_idx_r + 1'b1;
          state_nxt    = S_IDLE;
        end else if (out_free) begin
          emit         = 1'b1;
          emit_seg     = buf_r[scan_idx_r];
          emit_port    = SEG_W'(1) << pos;
          emit_last    = 1'b1;
          scan_idx_nxt = (scan_idx_r == LAST_SLOT) ? '0 : scan_idx_r + 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      S_ACK: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_ACK;
          emit_ok   = ok_r;
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      scan_idx_r     <= '0;
      cnt_r          <= '0;
      fill_mode_r    <= FILL_BLANK;
      now_r          <= '0;
      blink_active_r <= 1'b0;
      blink_lit_r    <= 1'b1;
      blink_timing_r <= 1'b0;
      blink_start_r  <= '0;
      wait_active_r  <= 1'b0;
      wait_timing_r  <= 1'b0;
      wait_start_r   <= '0;
      wait_step_r    <= '0;
      ok_r           <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      scan_idx_r     <= scan_idx_nxt;
      cnt_r          <= cnt_nxt;
      fill_mode_r    <= fill_mode_nxt;
      now_r          <= now_nxt;
      blink_active_r <= blink_active_nxt;
      blink_lit_r    <= blink_lit_nxt;
      blink_timing_r <= blink_timing_nxt;
      blink_start_r  <= blink_start_nxt;
      wait_active_r  <= wait_active_nxt;
      wait_timing_r  <= wait_timing_nxt;
      wait_start_r   <= wait_start_nxt;
      wait_step_r    <= wait_step_nxt;
      ok_r           <= ok_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= emit_kind;
      out_seg_r  <= emit_seg;
      out_port_r <= emit_port;
      out_ok_r   <= emit_ok;
      out_last_r <= emit_last;
    end
  end

  // digit buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGITS; i++) begin
        buf_r[i] <= BLANK_PAT_RST;
      end
    end else if (buf_we) begin
      buf_r[buf_waddr] <= buf_wdata;
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_on_r     <= BLINK_ON_RST;
      blink_off_r    <= BLINK_OFF_RST;
      wait_step_ms_r <= WAIT_STEP_RST;
      blink_mask_r   <= BLINK_MASK_RST;
      order_r        <= ORDER_RST;
      wait_pat_r     <= WAIT_PAT_RST;
      blank_pat_r    <= BLANK_PAT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BLINK_ON:   blink_on_r     <= cfg_data[MS_W-1:0];
        REG_BLINK_OFF:  blink_off_r    <= cfg_data[MS_W-1:0];
        REG_WAIT_STEP:  wait_step_ms_r <= cfg_data[MS_W-1:0];
        REG_BLINK_MASK: blink_mask_r   <= cfg_data[SEG_W-1:0];
        REG_ORDER:      order_r        <= cfg_data[ORDER_W-1:0];
        REG_WAIT_PAT:   wait_pat_r     <= cfg_data[SEG_W-1:0];
        REG_BLANK_PAT:  blank_pat_r    <= cfg_data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
